/* src/whole_word_replace_insert_delete_defines.svh */
// assertion macros for the whole-word edit block
`ifndef WHOLE_WORD_REPLACE_INSERT_DELETE_DEFINES_SVH
`define WHOLE_WORD_REPLACE_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTH
`define WWRID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wwrid assertion failed");
`define WWRID_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("wwrid forbidden condition seen");
`else
`define WWRID_ASSERT(lbl, prop)
`define WWRID_NEVER(lbl, cond)
`endif

`endif

/* src/wwrid_pkg.sv */
package wwrid_pkg;

  localparam int MAX_WORD_LEN = 16;
  localparam int WORD_BYTES   = 16;
  localparam int LEN_W        = 5;
  localparam int IDX_W        = $clog2(WORD_BYTES);
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;

  localparam logic [7:0] SPACE_CHAR = 8'd32;

  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_INSERT  = 2'd1;
  localparam logic [1:0] MODE_DELETE  = 2'd2;
  localparam logic [1:0] MODE_KEEP    = 2'd3;

  localparam logic [2:0] REG_EDIT_MODE = 3'd0;
  localparam logic [2:0] REG_PAT_LO    = 3'd1;
  localparam logic [2:0] REG_PAT_HI    = 3'd2;
  localparam logic [2:0] REG_PAT_LEN   = 3'd3;
  localparam logic [2:0] REG_SUB_LO    = 3'd4;
  localparam logic [2:0] REG_SUB_HI    = 3'd5;
  localparam logic [2:0] REG_SUB_LEN   = 3'd6;

  typedef struct packed {
    logic [1:0]       edit_mode;
    logic [63:0]      pat_lo;
    logic [63:0]      pat_hi;
    logic [LEN_W-1:0] pat_len;
    logic [63:0]      sub_lo;
    logic [63:0]      sub_hi;
    logic [LEN_W-1:0] sub_len;
  } cfg_t;

  function automatic logic [7:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [IDX_W-1:0] idx);
    logic [63:0] w;
    w = idx[IDX_W-1] ? hi : lo;
    return w[8*idx[IDX_W-2:0] +: 8];
  endfunction

endpackage

/* src/wwrid_if.sv */
interface wwrid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface wwrid_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output char_out, output run_last, output text_done,
                  input ready);
  modport sink (input valid, input char_out, input run_last, input text_done,
                output ready);
endinterface

/* src/wwrid_regs.sv */
module wwrid_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wwrid_pkg::ADDR_W-1:0]  paddr,
  input  logic [wwrid_pkg::DATA_W-1:0]  pwdata,
  output logic [wwrid_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output wwrid_pkg::cfg_t               cfg_o
);
  import wwrid_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_EDIT_MODE: cfg_d.edit_mode = pwdata[1:0];
        REG_PAT_LO:    cfg_d.pat_lo    = pwdata;
        REG_PAT_HI:    cfg_d.pat_hi    = pwdata;
        REG_PAT_LEN:   cfg_d.pat_len   = pwdata[LEN_W-1:0];
        REG_SUB_LO:    cfg_d.sub_lo    = pwdata;
        REG_SUB_HI:    cfg_d.sub_hi    = pwdata;
        REG_SUB_LEN:   cfg_d.sub_len   = pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EDIT_MODE: prdata = {{(DATA_W-2){1'b0}}, cfg_q.edit_mode};
      REG_PAT_LO:    prdata = cfg_q.pat_lo;
      REG_PAT_HI:    prdata = cfg_q.pat_hi;
      REG_PAT_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.pat_len};
      REG_SUB_LO:    prdata = cfg_q.sub_lo;
      REG_SUB_HI:    prdata = cfg_q.sub_hi;
      REG_SUB_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.sub_len};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pat_len: LEN_W'(1), sub_len: LEN_W'(1), default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/whole_word_replace_insert_delete.sv */
// whole-word find and replace, insert or delete over a byte stream
// text_i takes one text byte per request, end_of_text marks the final byte;
// words are split by the space byte and runs of spaces collapse to one.
// text_o gives the edited text one byte per request; run_last flags the
// final byte caused by an input request, text_done the final byte of a text.
// the pattern, substitute and edit mode sit behind the apb port, 64-bit
// registers at byte address 8 * index; write them only while idle.
// an ordinary word byte is buffered and leaves the block idle, so it is ready again next cycle.
// at a word end one shared byte comparator walks the buffered word, one
// byte a cycle, then a single emitter sends one byte a cycle while the
// output can take it: space, substitute and word, up to 34 bytes.
// no new input byte is taken until the closing request is finished.
// output bytes pass a one-byte staging register into the output register,
// so a stalled receiver simply holds the sequencer; nothing is dropped.
// reset clears the sequencer, word count, flags and registers; the word
// buffer needs no clearing since only filled entries are read.
`include "whole_word_replace_insert_delete_defines.svh"

module whole_word_replace_insert_delete (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wwrid_in_if.sink                      text_i,
  wwrid_out_if.source                   text_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wwrid_pkg::ADDR_W-1:0]  paddr,
  input  logic [wwrid_pkg::DATA_W-1:0]  pwdata,
  output logic [wwrid_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import wwrid_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLOSE  = 3'd1;
  localparam logic [2:0] ST_MATCH  = 3'd2;
  localparam logic [2:0] ST_SEP    = 3'd3;
  localparam logic [2:0] ST_WORD   = 3'd4;
  localparam logic [2:0] ST_CHAR   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  cfg_t cfg;

  wwrid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [7:0]       word_q [WORD_BYTES];

  logic [2:0]       state_q, state_d;
  logic [7:0]       char_q, char_d;
  logic             eot_q, eot_d;
  logic             close_q, close_d;
  logic             set_ovf_q, set_ovf_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic             src_sub_q, src_sub_d;
  logic             then_buf_q, then_buf_d;
  logic             then_char_q, then_char_d;
  logic             mism_q, mism_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             any_q, any_d;
  logic             stg_valid_q, stg_valid_d;
  logic [7:0]       stg_byte_q, stg_byte_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;
  logic             out_done_q, out_done_d;

  logic             in_take, buf_we, is_space, room;
  logic             can_push, emit_ok, emit;
  logic [7:0]       emit_byte, rd_byte, pat_byte, sub_byte, cur_byte;
  logic [LEN_W-1:0] sub_len_eff, word_len, idx_inc;

  assign text_i.ready     = (state_q == ST_IDLE);
  assign text_o.valid     = out_valid_q;
  assign text_o.char_out  = out_char_q;
  assign text_o.run_last  = out_last_q;
  assign text_o.text_done = out_done_q;

  assign in_take  = text_i.valid && (state_q == ST_IDLE);
  assign is_space = (text_i.char_in == SPACE_CHAR);
  assign room     = (count_q < LEN_W'(MAX_WORD_LEN));
  assign buf_we   = in_take && !is_space && !ovf_q && room;

  assign rd_byte     = word_q[idx_q[IDX_W-1:0]];
  assign pat_byte    = byte_of(cfg.pat_lo, cfg.pat_hi, idx_q[IDX_W-1:0]);
  assign sub_byte    = byte_of(cfg.sub_lo, cfg.sub_hi, idx_q[IDX_W-1:0]);
  assign sub_len_eff = (cfg.sub_len > LEN_W'(WORD_BYTES)) ? LEN_W'(WORD_BYTES) : cfg.sub_len;
  assign word_len    = src_sub_q ? sub_len_eff : count_q;
  assign cur_byte    = src_sub_q ? sub_byte : rd_byte;
  assign idx_inc     = idx_q + LEN_W'(1);

  assign can_push = !out_valid_q || text_o.ready;
  assign emit_ok  = !stg_valid_q || can_push;

  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    eot_d       = eot_q;
    close_d     = close_q;
    set_ovf_d   = set_ovf_q;
    idx_d       = idx_q;
    src_sub_d   = src_sub_q;
    then_buf_d  = then_buf_q;
    then_char_d = then_char_q;
    mism_d      = mism_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    any_d       = any_q;
    stg_valid_d = stg_valid_q;
    stg_byte_d  = stg_byte_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    emit        = 1'b0;
    emit_byte   = SPACE_CHAR;

    if (out_valid_q && text_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          char_d      = text_i.char_in;
          eot_d       = text_i.end_of_text;
          close_d     = is_space || text_i.end_of_text;
          set_ovf_d   = 1'b0;
          then_buf_d  = 1'b0;
          then_char_d = 1'b0;
          src_sub_d   = 1'b0;
          idx_d       = '0;
          if (is_space) begin
            state_d = ST_CLOSE;
          end else if (ovf_q) begin
            state_d = ST_CHAR;
          end else if (room) begin
            count_d = count_q + LEN_W'(1);
            state_d = text_i.end_of_text ? ST_CLOSE : ST_IDLE;
          end else begin
            // word too long: flush it and the new byte
            set_ovf_d   = 1'b1;
            then_char_d = 1'b1;
            state_d     = ST_SEP;
          end
        end
      end
      ST_CLOSE: begin
        if (ovf_q || count_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          mism_d  = (count_q != cfg.pat_len);
          idx_d   = '0;
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (mism_q || idx_q == count_q) begin
          idx_d = '0;
          if (mism_q || cfg.edit_mode == MODE_KEEP) begin
            src_sub_d = 1'b0;
            state_d   = ST_SEP;
          end else begin
            case (cfg.edit_mode)
              MODE_REPLACE: begin
                src_sub_d = 1'b1;
                state_d   = (sub_len_eff == '0) ? ST_FINISH : ST_SEP;
              end
              MODE_INSERT: begin
                src_sub_d  = (sub_len_eff != '0);
                then_buf_d = (sub_len_eff != '0);
                state_d    = ST_SEP;
              end
              MODE_DELETE: begin
                state_d = ST_FINISH;
              end
              default: begin
                src_sub_d = 1'b0;
                state_d   = ST_SEP;
              end
            endcase
          end
        end else begin
          if (rd_byte != pat_byte) begin
            mism_d = 1'b1;
          end
          idx_d = idx_inc;
        end
      end
      ST_SEP: begin
        if (!any_q) begin
          any_d   = 1'b1;
          idx_d   = '0;
          state_d = ST_WORD;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = SPACE_CHAR;
          idx_d     = '0;
          state_d   = ST_WORD;
        end
      end
      ST_WORD: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = cur_byte;
          idx_d     = idx_inc;
          if (idx_inc == word_len) begin
            idx_d = '0;
            if (then_buf_q) begin
              then_buf_d = 1'b0;
              src_sub_d  = 1'b0;
              state_d    = ST_SEP;
            end else if (then_char_q) begin
              state_d = ST_CHAR;
            end else begin
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_CHAR: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = char_q;
          state_d   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stg_valid_q || can_push) begin
          if (stg_valid_q) begin
            out_valid_d = 1'b1;
            out_char_d  = stg_byte_q;
            out_last_d  = 1'b1;
            out_done_d  = eot_q;
          end
          stg_valid_d = 1'b0;
          if (set_ovf_q) begin
            ovf_d   = 1'b1;
            count_d = '0;
          end
          if (close_q) begin
            ovf_d   = 1'b0;
            count_d = '0;
          end
          if (eot_q) begin
            any_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // staged byte moves on once a later byte of the same request exists
    if (emit) begin
      if (stg_valid_q) begin
        out_valid_d = 1'b1;
        out_char_d  = stg_byte_q;
        out_last_d  = 1'b0;
        out_done_d  = 1'b0;
      end
      stg_valid_d = 1'b1;
      stg_byte_d  = emit_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      word_q[count_q[IDX_W-1:0]] <= text_i.char_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      char_q      <= '0;
      eot_q       <= 1'b0;
      close_q     <= 1'b0;
      set_ovf_q   <= 1'b0;
      idx_q       <= '0;
      src_sub_q   <= 1'b0;
      then_buf_q  <= 1'b0;
      then_char_q <= 1'b0;
      mism_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      any_q       <= 1'b0;
      stg_valid_q <= 1'b0;
      stg_byte_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      char_q      <= char_d;
      eot_q       <= eot_d;
      close_q     <= close_d;
      set_ovf_q   <= set_ovf_d;
      idx_q       <= idx_d;
      src_sub_q   <= src_sub_d;
      then_buf_q  <= then_buf_d;
      then_char_q <= then_char_d;
      mism_q      <= mism_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      any_q       <= any_d;
      stg_valid_q <= stg_valid_d;
      stg_byte_q  <= stg_byte_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      out_done_q  <= out_done_d;
    end
  end

  `WWRID_NEVER(a_idle_stage_empty, state_q == ST_IDLE && stg_valid_q)
  `WWRID_ASSERT(a_ovf_no_count, ovf_q |-> count_q == '0)
  `WWRID_NEVER(a_count_bound, count_q > LEN_W'(MAX_WORD_LEN))
  `WWRID_ASSERT(a_word_idx, state_q == ST_WORD |-> idx_q < word_len)
  `WWRID_ASSERT(a_final_push,
    (state_q == ST_FINISH && stg_valid_q && can_push) |=> out_valid_q && out_last_q)

endmodule

/* tb/sv/tb_whole_word_replace_insert_delete.sv */
module tb_whole_word_replace_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import wwrid_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASE_CHARS   = 10;

  typedef enum int {RX_STEADY, RX_COIN, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_done;
  } edit_byte_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wwrid_in_if  text_if ();
  wwrid_out_if edit_if ();

  whole_word_replace_insert_delete u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .text_o  (edit_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block
  cfg_t        cfg_shadow;
  logic [7:0]  word_buf [MAX_WORD_LEN];
  int unsigned word_len;
  bit          word_too_long;
  bit          text_started;
  edit_byte_t  step_bytes [$];
  edit_byte_t  edited_q [$];
  text_byte_t  text_q [$];

  bit          in_taken;
  bit          tx_gaps;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_e    rx_mode;
  bit          rx_hold_req;
  int unsigned rx_hold_left;
  int unsigned rx_stall_left;

  int unsigned n_errors;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_texts;
  int unsigned n_settings;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("** whole_word_replace_insert_delete: FAILED **");
    $finish;
  end

  function automatic logic [7:0] pat_char(input int unsigned i);
    return (i < 8) ? cfg_shadow.pat_lo[8*i +: 8] : cfg_shadow.pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] sub_char(input int unsigned i);
    return (i < 8) ? cfg_shadow.sub_lo[8*i +: 8] : cfg_shadow.sub_hi[8*(i-8) +: 8];
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    step_bytes.push_back('{ch: b, run_last: 1'b0, text_done: 1'b0});
  endfunction

  // one space before every word but the first of a text
  function automatic void push_gap();
    if (text_started) push_byte(SPACE_CHAR);
    text_started = 1'b1;
  endfunction

  function automatic void push_word();
    int unsigned i;
    if (word_len == 0) return;
    push_gap();
    for (i = 0; i < word_len; i++) push_byte(word_buf[i]);
  endfunction

  function automatic void push_subst();
    int unsigned n;
    int unsigned i;
    n = (cfg_shadow.sub_len > MAX_WORD_LEN) ? MAX_WORD_LEN : cfg_shadow.sub_len;
    if (n == 0) return;
    push_gap();
    for (i = 0; i < n; i++) push_byte(sub_char(i));
  endfunction

  function automatic bit word_hits();
    int unsigned i;
    if (word_len == 0 || word_len != cfg_shadow.pat_len) return 1'b0;
    for (i = 0; i < word_len; i++) begin
      if (word_buf[i] != pat_char(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void close_word();
    if (!word_too_long && word_len != 0) begin
      if (!word_hits() || cfg_shadow.edit_mode == MODE_KEEP) begin
        push_word();
      end else if (cfg_shadow.edit_mode == MODE_REPLACE) begin
        push_subst();
      end else if (cfg_shadow.edit_mode == MODE_INSERT) begin
        push_subst();
        push_word();
      end
    end
    word_len      = 0;
    word_too_long = 1'b0;
  endfunction

  function automatic void edit_text_byte(input text_byte_t t);
    step_bytes.delete();
    if (t.ch == SPACE_CHAR) begin
      close_word();
    end else if (word_too_long) begin
      push_byte(t.ch);
    end else if (word_len < MAX_WORD_LEN) begin
      word_buf[word_len] = t.ch;
      word_len++;
    end else begin
      push_word();
      push_byte(t.ch);
      word_too_long = 1'b1;
      word_len      = 0;
    end
    if (t.eot) begin
      close_word();
      text_started = 1'b0;
    end
    if (step_bytes.size() > 0) begin
      step_bytes[$].run_last  = 1'b1;
      step_bytes[$].text_done = t.eot;
    end
    foreach (step_bytes[i]) edited_q.push_back(step_bytes[i]);
  endfunction

  always @(posedge clk_i) begin
    edit_byte_t want;
    if (rst_ni) begin
      in_taken = text_if.valid && text_if.ready;
      if (in_taken) begin
        edit_text_byte('{ch: text_if.char_in, eot: text_if.end_of_text});
        n_in++;
        if (text_if.end_of_text) n_texts++;
      end
      if (edit_if.valid && edit_if.ready) begin
        n_out++;
        if (edited_q.size() == 0) begin
          $error("unexpected edited byte: char_out %02h", edit_if.char_out);
          n_errors++;
        end else begin
          want = edited_q.pop_front();
          if (edit_if.char_out !== want.ch) begin
            $error("char_out: expected %02h, got %02h", want.ch, edit_if.char_out);
            n_errors++;
          end
          if (edit_if.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, edit_if.run_last);
            n_errors++;
          end
          if (edit_if.text_done !== want.text_done) begin
            $error("text_done: expected %0b, got %0b", want.text_done, edit_if.text_done);
            n_errors++;
          end
        end
      end
    end
  end

  // sender: bursts of requests with random gaps
  always @(negedge clk_i) begin
    text_byte_t nxt;
    bit         drive;
    if (rst_ni) begin
      drive = text_if.valid && !in_taken;
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_q.size() > 0) begin
          nxt   = text_q.pop_front();
          drive = 1'b1;
          text_if.char_in     <= nxt.ch;
          text_if.end_of_text <= nxt.eot;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0 && tx_gaps) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end
      text_if.valid <= drive;
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(negedge clk_i) begin
    bit take;
    if (rst_ni) begin
      if (rx_hold_req) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        take = 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        take = 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY: begin
            take = 1'b1;
          end
          RX_COIN: begin
            take = ($urandom_range(0, 3) != 0);
          end
          default: begin
            take = 1'b1;
            if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 15);
          end
        endcase
      end
      edit_if.ready <= take;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cfg(input cfg_t c);
    apb_write(REG_EDIT_MODE, 64'(c.edit_mode));
    apb_write(REG_PAT_LO, c.pat_lo);
    apb_write(REG_PAT_HI, c.pat_hi);
    apb_write(REG_PAT_LEN, 64'(c.pat_len));
    apb_write(REG_SUB_LO, c.sub_lo);
    apb_write(REG_SUB_HI, c.sub_hi);
    apb_write(REG_SUB_LEN, 64'(c.sub_len));
    cfg_shadow = c;
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (text_q.size() != 0 || text_if.valid || edited_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (b == SPACE_CHAR);
    return b;
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic eot);
    text_q.push_back('{ch: ch, eot: eot});
  endfunction

  function automatic void push_str(input string s, input logic eot);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], eot && (i == s.len() - 1));
  endfunction

  function automatic cfg_t make_cfg(input logic [1:0] mode, input int unsigned plen,
                                    input int unsigned slen);
    cfg_t c;
    int   i;
    c.edit_mode = mode;
    c.pat_len   = LEN_W'(plen);
    c.sub_len   = LEN_W'(slen);
    for (i = 0; i < 8; i++) begin
      c.pat_lo[8*i +: 8] = text_char();
      c.pat_hi[8*i +: 8] = text_char();
    end
    c.sub_lo = {$urandom, $urandom};
    c.sub_hi = {$urandom, $urandom};
    return c;
  endfunction

  // words drawn mostly from the pattern, with near misses and long words mixed in
  function automatic void gen_text(input int unsigned n_chars, input bit close_text,
                                   input bit start_long);
    logic [7:0]  w [$];
    logic [7:0]  b;
    int unsigned count;
    int unsigned plen;
    int unsigned k;
    int unsigned i;
    int unsigned n;
    bit          first;
    count = 0;
    first = 1'b1;
    plen  = cfg_shadow.pat_len;
    if ($urandom_range(0, 5) == 0) begin
      push_char(SPACE_CHAR, 1'b0);
      count++;
    end
    while (count < n_chars) begin
      w.delete();
      k = (first && start_long) ? 15 : $urandom_range(0, 15);
      first = 1'b0;
      if (k < 9 && plen >= 1 && plen <= MAX_WORD_LEN) begin
        for (i = 0; i < plen; i++) w.push_back(pat_char(i));
        if (k == 7) begin
          i = $urandom_range(0, plen - 1);
          do b = text_char(); while (b == w[i]);
          w[i] = b;
        end else if (k == 8) begin
          if (plen > 1 && $urandom_range(0, 1) == 1) void'(w.pop_back());
          else w.push_back(text_char());
        end
      end else begin
        if (k == 15) n = $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 4);
        else if (k > 12) n = $urandom_range(7, MAX_WORD_LEN);
        else n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) w.push_back(text_char());
      end
      foreach (w[j]) push_char(w[j], 1'b0);
      count += w.size();
      if (count >= n_chars) begin
        if (!close_text) push_char(SPACE_CHAR, 1'b0);
        else if ($urandom_range(0, 4) == 0) push_char(SPACE_CHAR, 1'b1);
        else text_q[$].eot = 1'b1;
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
        for (i = 0; i < n; i++) push_char(SPACE_CHAR, 1'b0);
        count += n;
      end
    end
  endfunction

  task automatic run_phase(input cfg_t c, input rx_mode_e rxm, input bit gaps,
                           input bit start_long, input bit hold);
    wait_drained();
    set_cfg(c);
    rx_mode     = rxm;
    tx_gaps     = gaps;
    rx_hold_req = hold;
    gen_text(PHASE_CHARS, 1'b1, start_long);
  endtask

  initial begin
    cfg_t c;
    text_if.valid       = 1'b0;
    text_if.char_in     = '0;
    text_if.end_of_text = 1'b0;
    edit_if.ready       = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    cfg_shadow = '{edit_mode: MODE_REPLACE, pat_len: LEN_W'(1), sub_len: LEN_W'(1),
                   default: '0};
    word_len      = 0;
    word_too_long = 1'b0;
    text_started  = 1'b0;
    rx_mode       = RX_STEADY;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: a zero byte is the pattern and its own substitute
    push_char(SPACE_CHAR, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(SPACE_CHAR, 1'b0);
    push_char(8'hff, 1'b0);
    push_char(SPACE_CHAR, 1'b0);
    push_char(SPACE_CHAR, 1'b0);
    push_char("a", 1'b1);

    // delete, ending on a dropped word, then a text of one space
    wait_drained();
    c = make_cfg(MODE_DELETE, 2, 2);
    c.pat_lo = 64'h6261;
    set_cfg(c);
    push_str("ab x ab", 1'b1);
    push_char(SPACE_CHAR, 1'b1);

    // insert with an empty substitute
    wait_drained();
    c.edit_mode = MODE_INSERT;
    c.sub_len   = '0;
    set_cfg(c);
    push_str("ab", 1'b1);

    run_phase(make_cfg(MODE_REPLACE, 3, 5), RX_STEADY, 1'b0, 1'b1, 1'b0);
    run_phase(make_cfg(MODE_INSERT, MAX_WORD_LEN, MAX_WORD_LEN), RX_COIN, 1'b1, 1'b0, 1'b1);
    run_phase(make_cfg(MODE_DELETE, 1, 1), RX_BURSTY, 1'b1, 1'b0, 1'b0);
    run_phase(make_cfg(MODE_KEEP, 2, 3), RX_COIN, 1'b1, 1'b0, 1'b1);
    run_phase(make_cfg(MODE_REPLACE, 0, 0), RX_BURSTY, 1'b0, 1'b0, 1'b0);
    run_phase(make_cfg(MODE_INSERT, 20, 31), RX_STEADY, 1'b1, 1'b1, 1'b0);

    // sender pauses mid-text until the output has drained
    wait_drained();
    set_cfg(make_cfg(MODE_REPLACE, $urandom_range(1, MAX_WORD_LEN), 0));
    rx_mode = RX_BURSTY;
    tx_gaps = 1'b1;
    gen_text(PHASE_CHARS / 2, 1'b0, 1'b0);
    wait_drained();
    gen_text(PHASE_CHARS / 2, 1'b1, 1'b0);

    c = make_cfg(MODE_INSERT, 4, MAX_WORD_LEN);
    c.pat_lo = 64'h00ff00ff_00ff00ff;
    c.pat_hi = 64'h00ff00ff_00ff00ff;
    c.sub_lo = '1;
    c.sub_hi = '0;
    run_phase(c, RX_COIN, 1'b1, 1'b0, 1'b0);
    run_phase(make_cfg(MODE_DELETE, $urandom_range(1, MAX_WORD_LEN),
                       $urandom_range(1, MAX_WORD_LEN)), RX_BURSTY, 1'b1, 1'b0, 1'b0);

    wait_drained();
    $display("run covered %0d text bytes in %0d texts under %0d register settings",
             n_in, n_texts, n_settings);
    $display("all four edit modes, long words and empty words; %0d edited bytes checked",
             n_out);
    if (n_errors == 0) begin
      $display("** whole_word_replace_insert_delete: PASSED **");
    end else begin
      $display("** whole_word_replace_insert_delete: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/wwrid_pkg.sv
src/wwrid_if.sv
src/wwrid_regs.sv
src/whole_word_replace_insert_delete.sv
tb/sv/tb_whole_word_replace_insert_delete.sv
